/* hdl/arlr_pkg.sv */
package arlr_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int ETYPE_W = 16;
    localparam int OP_W   = 16;
    localparam int ACT_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 208;

    localparam logic [ETYPE_W-1:0] ETH_ARP  = 16'h0806;
    localparam logic [ETYPE_W-1:0] ETH_IPV4 = 16'h0800;
    localparam logic [OP_W-1:0]    OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0]    OP_REPLY   = 16'd2;
    localparam logic [MAC_W-1:0]   BCAST_MAC  = {6{8'hFF}};

    localparam logic [ACT_W-1:0] ACT_FORWARD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CONSUMED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLY    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REQUEST  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_MAC  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_MAC = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_IP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_IP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAIN_MAC = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input transfer, clear scan index and hit
        logic rd_en;     // read table entry at scan index
        logic inc_idx;   // advance scan index
        logic set_hit;   // current entry matched
        logic finish;    // load output register, learn if needed
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_search;
        logic scan_end;
        logic match;
        logic out_free;
    } sts_t;

endpackage

/* hdl/arp_resolving_l3_border_rewriter.sv */
// ARP-resolving L3 border rewriter. Each input transfer carries one frame's
// parsed header and its ingress side (s_tuser: 0 right port, 1 left port); one
// output transfer comes back with the action in m_tuser (0 forward, 1 consumed,
// 2 send ARP reply on ingress, 3 drop and send ARP request) and the rewritten
// MACs and ARP fields in m_tdata. ARP replies are learned into an IP-to-MAC
// table filled in arrival order; it stops learning when full and is never
// aged. An item is captured; if a search is needed, the filled entries are
// read and compared in turn through the table's single, registered read port
// until one matches or none is left. The result is loaded once the output
// register is free and is held there while the next item is taken in; a new
// item is taken only while idle. Port registers are written through
// cfg_wr_en/cfg_addr/cfg_wdata (0 left MAC, 1 right MAC, 2 left IP, 3 right
// IP, 4 chain next-hop MAC); the user must write them only while idle, which
// the block does not enforce. No clearing pass is needed after reset.
module arp_resolving_l3_border_rewriter
#(
    parameter int TABLE_ENTRIES = arlr_pkg::DEF_TABLE_ENTRIES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [arlr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [arlr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // header in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_type[15:0], frame_dst_mac[63:16], frame_src_mac[111:64],
    // arp_opcode[127:112], arp_sender_ip[159:128], arp_sender_mac[207:160],
    // arp_target_ip[239:208], ip_destination[271:240]
    input  logic [arlr_pkg::IN_DATA_W-1:0]   s_tdata,
    // direction[0]
    input  logic                             s_tuser,
    // result out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_dst_mac[47:0], out_src_mac[95:48], out_arp_sender_ip[127:96],
    // out_arp_target_ip[159:128], out_arp_target_mac[207:160]
    output logic [arlr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // action[1:0]
    output logic [arlr_pkg::ACT_W-1:0]       m_tuser
);
    import arlr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller sequences capture, table scan and result load
    arlr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath holds config, the item, the table and the output register
    arlr_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_dir    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* hdl/arlr_ctrl.sv */
module arlr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  arlr_pkg::sts_t sts,
    output arlr_pkg::cmd_t cmd
);
    import arlr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_CMP    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!sts.need_search || sts.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.match)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_capture_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_READ)
        else $error("capture not followed by scan");
    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result loaded into a full output register");
    a_hit_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_hit |-> (sts.match && $past(cmd.rd_en)))
        else $error("hit without a fresh table read");
`endif

endmodule

/* hdl/arlr_datapath.sv */
module arlr_datapath
#(
    parameter int TABLE_ENTRIES = arlr_pkg::DEF_TABLE_ENTRIES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [arlr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [arlr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [arlr_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                                in_dir,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [arlr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [arlr_pkg::ACT_W-1:0]          m_tuser,
    input  arlr_pkg::cmd_t                      cmd,
    output arlr_pkg::sts_t                      sts
);
    import arlr_pkg::*;

    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // configuration
    logic [MAC_W-1:0] left_mac_reg, right_mac_reg, chain_mac_reg;
    logic [IP_W-1:0]  left_ip_reg, right_ip_reg;

    // captured item
    logic               dir_reg;
    logic [ETYPE_W-1:0] etype_reg;
    logic [MAC_W-1:0]   fdst_reg, fsrc_reg, smac_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IP_W-1:0]    sip_reg, tip_reg, ipdst_reg;

    // table
    logic [IP_W-1:0]  mem_ip  [TABLE_ENTRIES];
    logic [MAC_W-1:0] mem_mac [TABLE_ENTRIES];
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;
    logic [CNT_W-1:0] used_reg, idx_reg;
    logic             hit_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [ACT_W-1:0]      out_act_reg;

    logic             is_arp, req_ours, is_reply, ipv4_rl, learn;
    logic [MAC_W-1:0] in_mac;
    logic [IP_W-1:0]  in_ip, key;
    logic [ACT_W-1:0] r_act;
    logic [MAC_W-1:0] r_dst, r_src, r_tmac;
    logic [IP_W-1:0]  r_sip, r_tip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_mac_reg  <= '0;
            right_mac_reg <= '0;
            left_ip_reg   <= '0;
            right_ip_reg  <= '0;
            chain_mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_LEFT_MAC:  left_mac_reg  <= cfg_wdata;
                REG_RIGHT_MAC: right_mac_reg <= cfg_wdata;
                REG_LEFT_IP:   left_ip_reg   <= cfg_wdata[IP_W-1:0];
                REG_RIGHT_IP:  right_ip_reg  <= cfg_wdata[IP_W-1:0];
                REG_CHAIN_MAC: chain_mac_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dir_reg   <= in_dir;
            etype_reg <= in_data[15:0];
            fdst_reg  <= in_data[63:16];
            fsrc_reg  <= in_data[111:64];
            op_reg    <= in_data[127:112];
            sip_reg   <= in_data[159:128];
            smac_reg  <= in_data[207:160];
            tip_reg   <= in_data[239:208];
            ipdst_reg <= in_data[271:240];
        end
    end

    // decode of the held item
    always_comb
    begin
        in_mac   = dir_reg ? left_mac_reg : right_mac_reg;
        in_ip    = dir_reg ? left_ip_reg : right_ip_reg;
        is_arp   = (etype_reg == ETH_ARP);
        req_ours = is_arp && (op_reg == OP_REQUEST) && (in_ip == tip_reg);
        is_reply = is_arp && (op_reg == OP_REPLY);
        ipv4_rl  = !dir_reg && (etype_reg == ETH_IPV4);
        key      = is_reply ? sip_reg : ipdst_reg;
        learn    = is_reply && !hit_reg && (used_reg < CNT_W'(TABLE_ENTRIES));
    end

    always_comb
    begin
        r_act  = ACT_FORWARD;
        r_dst  = '0;
        r_src  = '0;
        r_sip  = '0;
        r_tip  = '0;
        r_tmac = '0;
        if (req_ours)
        begin
            r_act  = ACT_REPLY;
            r_dst  = smac_reg;
            r_src  = in_mac;
            r_sip  = in_ip;
            r_tip  = sip_reg;
            r_tmac = smac_reg;
        end
        else if (is_reply)
        begin
            r_act = ACT_CONSUMED;
        end
        else if (ipv4_rl)
        begin
            if (hit_reg)
            begin
                r_dst = rd_mac_reg;
                r_src = left_mac_reg;
            end
            else
            begin
                r_act = ACT_REQUEST;
                r_dst = BCAST_MAC;
                r_src = left_mac_reg;
                r_sip = left_ip_reg;
                r_tip = ipdst_reg;
            end
        end
        else if (!dir_reg)
        begin
            r_dst = fdst_reg;
            r_src = fsrc_reg;
        end
        else
        begin
            r_dst = chain_mac_reg;
            r_src = right_mac_reg;
        end
    end

    // table memory: one read port at the scan index, one write port at the fill count
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_ip_reg  <= mem_ip[idx_reg[AW-1:0]];
            rd_mac_reg <= mem_mac[idx_reg[AW-1:0]];
        end
        if (cmd.finish && learn)
        begin
            mem_ip[used_reg[AW-1:0]]  <= sip_reg;
            mem_mac[used_reg[AW-1:0]] <= smac_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.inc_idx)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (cmd.set_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.finish && learn)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_act_reg  <= r_act;
            out_data_reg <= {r_tmac, r_tip, r_sip, r_src, r_dst};
        end
    end

    assign sts.need_search = !req_ours && (is_reply || ipv4_rl);
    assign sts.scan_end    = (idx_reg == used_reg);
    assign sts.match       = (rd_ip_reg == key);
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_act_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count past table size");
    a_learn_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && learn) |=> used_reg == $past(used_reg) + CNT_W'(1))
        else $error("learned entry not counted");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> idx_reg < used_reg)
        else $error("table read beyond filled entries");
`endif

endmodule
